// ----- rtl/dps_pkg.sv -----
// Package for the DCC packet bit serializer: types, constants and microcode ROM.
package dps_pkg;

  localparam int unsigned BYTE_BITS     = 8;
  localparam int unsigned CNT_W         = 6;
  localparam int unsigned PREAMBLE_MAX  = 32;
  localparam int unsigned PREAMBLE_RST  = 16;

  typedef enum logic [2:0] {
    ROLE_PREAMBLE  = 3'd0,
    ROLE_START     = 3'd1,
    ROLE_DATA      = 3'd2,
    ROLE_SEPARATOR = 3'd3,
    ROLE_CHECKSUM  = 3'd4,
    ROLE_END       = 3'd5
  } role_e;

  typedef enum logic [2:0] {
    PC_WAIT  = 3'd0,
    PC_PRE   = 3'd1,
    PC_START = 3'd2,
    PC_DATA  = 3'd3,
    PC_SEP   = 3'd4,
    PC_CSUM  = 3'd5,
    PC_END   = 3'd6
  } pc_e;

  typedef enum logic [1:0] {
    BIT_ONE   = 2'd0,
    BIT_ZERO  = 2'd1,
    BIT_SHIFT = 2'd2
  } bit_sel_e;

  typedef enum logic [1:0] {
    ACC_NONE        = 2'd0,
    ACC_ALWAYS      = 2'd1,
    ACC_IF_NOT_LAST = 2'd2
  } acc_e;

  typedef enum logic [1:0] {
    RL_NONE        = 2'd0,
    RL_ALWAYS      = 2'd1,
    RL_IF_NOT_LAST = 2'd2
  } rl_e;

  // One microcode word.
  typedef struct packed {
    logic     emit;
    bit_sel_e bit_sel;
    role_e    role;
    acc_e     acc;
    logic     loop;      // repeat step until the counter reaches one
    logic     jmp_last;  // take alt_pc when the current byte is the last
    pc_e      next_pc;
    pc_e      alt_pc;
    logic     ld_csum;
    rl_e      run_last;
    logic     pkt_end;
    logic     set_inside;
    logic     clr_pkt;
  } uword_t;

  // Resolved controls, sequencer to datapath.
  typedef struct packed {
    logic     emit;
    bit_sel_e bit_sel;
    role_e    role;
    logic     run_last;
    logic     pkt_end;
    logic     accept;
    logic     ld_csum;
    logic     set_inside;
    logic     clr_pkt;
  } ctrl_t;

  // Status, datapath to sequencer.
  typedef struct packed {
    logic             in_pkt;
    logic             last;
    logic             slot_free;
    logic [CNT_W-1:0] pre_len;
  } status_t;

  function automatic uword_t ucode_rd(pc_e pc);
    uword_t w;
    w = '{emit: 1'b0, bit_sel: BIT_ZERO, role: ROLE_PREAMBLE, acc: ACC_NONE, loop: 1'b0,
          jmp_last: 1'b0, next_pc: PC_WAIT, alt_pc: PC_WAIT, ld_csum: 1'b0,
          run_last: RL_NONE, pkt_end: 1'b0, set_inside: 1'b0, clr_pkt: 1'b0};
    case (pc)
      PC_WAIT: begin
        w.acc     = ACC_ALWAYS;
        w.next_pc = PC_WAIT;
      end
      PC_PRE: begin
        w.emit    = 1'b1;
        w.bit_sel = BIT_ONE;
        w.role    = ROLE_PREAMBLE;
        w.loop    = 1'b1;
        w.next_pc = PC_START;
      end
      PC_START: begin
        w.emit       = 1'b1;
        w.bit_sel    = BIT_ZERO;
        w.role       = ROLE_START;
        w.set_inside = 1'b1;
        w.next_pc    = PC_DATA;
      end
      PC_DATA: begin
        w.emit    = 1'b1;
        w.bit_sel = BIT_SHIFT;
        w.role    = ROLE_DATA;
        w.loop    = 1'b1;
        w.next_pc = PC_SEP;
      end
      PC_SEP: begin
        w.emit     = 1'b1;
        w.bit_sel  = BIT_ZERO;
        w.role     = ROLE_SEPARATOR;
        w.acc      = ACC_IF_NOT_LAST;
        w.jmp_last = 1'b1;
        w.ld_csum  = 1'b1;
        w.run_last = RL_IF_NOT_LAST;
        w.next_pc  = PC_WAIT;
        w.alt_pc   = PC_CSUM;
      end
      PC_CSUM: begin
        w.emit    = 1'b1;
        w.bit_sel = BIT_SHIFT;
        w.role    = ROLE_CHECKSUM;
        w.loop    = 1'b1;
        w.next_pc = PC_END;
      end
      PC_END: begin
        w.emit     = 1'b1;
        w.bit_sel  = BIT_ONE;
        w.role     = ROLE_END;
        w.run_last = RL_ALWAYS;
        w.pkt_end  = 1'b1;
        w.clr_pkt  = 1'b1;
        w.next_pc  = PC_WAIT;
      end
      default: begin
        w.next_pc = PC_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/dps_seq.sv -----
// Microcode sequencer: program counter, step counter, branch resolution.
module dps_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dps_pkg::status_t status_i,
  output dps_pkg::ctrl_t   ctrl_o
);

  dps_pkg::pc_e                pc_q, pc_d;
  logic [dps_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  dps_pkg::uword_t             uw;
  dps_pkg::pc_e                tgt;
  logic                        accept;
  logic                        go;
  logic                        last_bit;

  assign uw = dps_pkg::ucode_rd(pc_q);

  assign in_ready_o = (uw.acc == dps_pkg::ACC_ALWAYS) ||
                      ((uw.acc == dps_pkg::ACC_IF_NOT_LAST) && !status_i.last &&
                       status_i.slot_free);
  assign accept     = in_ready_o && in_valid_i;
  assign go         = uw.emit ? status_i.slot_free : accept;
  assign last_bit   = (cnt_q == dps_pkg::CNT_W'(1));

  always_comb begin
    if (accept) begin
      tgt = status_i.in_pkt ? dps_pkg::PC_DATA : dps_pkg::PC_PRE;
    end else if (uw.jmp_last && status_i.last) begin
      tgt = uw.alt_pc;
    end else begin
      tgt = uw.next_pc;
    end
  end

  always_comb begin
    pc_d  = pc_q;
    cnt_d = cnt_q;
    if (go) begin
      if (uw.loop && !last_bit) begin
        cnt_d = cnt_q - dps_pkg::CNT_W'(1);
      end else begin
        pc_d  = tgt;
        cnt_d = (tgt == dps_pkg::PC_PRE) ? status_i.pre_len
                                         : dps_pkg::CNT_W'(dps_pkg::BYTE_BITS);
      end
    end
  end

  always_comb begin
    ctrl_o.emit       = go && uw.emit;
    ctrl_o.bit_sel    = uw.bit_sel;
    ctrl_o.role       = uw.role;
    ctrl_o.run_last   = (uw.run_last == dps_pkg::RL_ALWAYS) ||
                        ((uw.run_last == dps_pkg::RL_IF_NOT_LAST) && !status_i.last);
    ctrl_o.pkt_end    = uw.pkt_end;
    ctrl_o.accept     = accept;
    ctrl_o.ld_csum    = go && uw.ld_csum && status_i.last;
    ctrl_o.set_inside = go && uw.set_inside;
    ctrl_o.clr_pkt    = go && uw.clr_pkt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= dps_pkg::PC_WAIT;
      cnt_q <= '0;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/dps_dp.sv -----
// Datapath: byte shifter, checksum, preamble length register, output register.
module dps_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dps_pkg::CNT_W-1:0]     cfg_wdata_i,
  input  logic [dps_pkg::BYTE_BITS-1:0] data_byte_i,
  input  logic                          last_byte_i,
  input  dps_pkg::ctrl_t                ctrl_i,
  output dps_pkg::status_t              status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          line_bit_o,
  output dps_pkg::role_e                bit_role_o,
  output logic                          run_last_o,
  output logic                          packet_end_o
);

  logic [dps_pkg::CNT_W-1:0]     pre_len_q, pre_len_d;
  logic [dps_pkg::BYTE_BITS-1:0] shift_q, shift_d;
  logic [dps_pkg::BYTE_BITS-1:0] csum_q, csum_d;
  logic                          last_q, last_d;
  logic                          inside_q, inside_d;
  logic                          valid_q, valid_d;
  logic                          bit_q, bit_d;
  dps_pkg::role_e                role_q, role_d;
  logic                          rl_q, rl_d;
  logic                          pe_q, pe_d;
  logic                          slot_free;

  assign slot_free = !valid_q || out_ready_i;

  // Clamp written preamble length to 1..32.
  always_comb begin
    pre_len_d = pre_len_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i > dps_pkg::CNT_W'(dps_pkg::PREAMBLE_MAX)) begin
        pre_len_d = dps_pkg::CNT_W'(dps_pkg::PREAMBLE_MAX);
      end else if (cfg_wdata_i == '0) begin
        pre_len_d = dps_pkg::CNT_W'(1);
      end else begin
        pre_len_d = cfg_wdata_i;
      end
    end
  end

  always_comb begin
    shift_d  = shift_q;
    csum_d   = csum_q;
    last_d   = last_q;
    inside_d = inside_q;
    if (ctrl_i.accept) begin
      shift_d = data_byte_i;
      csum_d  = csum_q ^ data_byte_i;
      last_d  = last_byte_i;
    end else if (ctrl_i.ld_csum) begin
      shift_d = csum_q;
    end else if (ctrl_i.emit && (ctrl_i.bit_sel == dps_pkg::BIT_SHIFT)) begin
      shift_d = {shift_q[dps_pkg::BYTE_BITS-2:0], 1'b0};
    end
    if (ctrl_i.set_inside) begin
      inside_d = 1'b1;
    end
    if (ctrl_i.clr_pkt) begin
      inside_d = 1'b0;
      csum_d   = '0;
    end
  end

  always_comb begin
    valid_d = valid_q;
    bit_d   = bit_q;
    role_d  = role_q;
    rl_d    = rl_q;
    pe_d    = pe_q;
    if (ctrl_i.emit) begin
      valid_d = 1'b1;
      role_d  = ctrl_i.role;
      rl_d    = ctrl_i.run_last;
      pe_d    = ctrl_i.pkt_end;
      case (ctrl_i.bit_sel)
        dps_pkg::BIT_ONE:   bit_d = 1'b1;
        dps_pkg::BIT_SHIFT: bit_d = shift_q[dps_pkg::BYTE_BITS-1];
        default:            bit_d = 1'b0;
      endcase
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_len_q <= dps_pkg::CNT_W'(dps_pkg::PREAMBLE_RST);
      csum_q    <= '0;
      last_q    <= 1'b0;
      inside_q  <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      pre_len_q <= pre_len_d;
      csum_q    <= csum_d;
      last_q    <= last_d;
      inside_q  <= inside_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    bit_q   <= bit_d;
    role_q  <= role_d;
    rl_q    <= rl_d;
    pe_q    <= pe_d;
  end

  assign status_o.in_pkt    = inside_q;
  assign status_o.last      = last_q;
  assign status_o.slot_free = slot_free;
  assign status_o.pre_len   = pre_len_q;

  assign out_valid_o  = valid_q;
  assign line_bit_o   = bit_q;
  assign bit_role_o   = role_q;
  assign run_last_o   = rl_q;
  assign packet_end_o = pe_q;

endmodule

// ----- rtl/dcc_packet_bit_serializer.sv -----
// Top level: DCC packet framing, bytes in, track bits out, one bit per transaction.
// An accepted byte is loaded into the shifter; its bits leave via the output register.
// Throughput: one bit per cycle when the sink keeps tready high; a middle byte gives
// 8 data bits and a separator, a first byte adds preamble_bits + 1, a last byte adds 9.
// A later byte of a packet is taken at the separator step, or else at the bitless wait step.
// Reset (rst_ni low, asynchronous): preamble length 16, checksum clear, no open packet.
module dcc_packet_bit_serializer (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Preamble length register.
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  // Byte stream in.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last_byte
  // Line bit stream out.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] line_bit, [7:1] zero
  output logic [3:0] m_axis_tuser,   // [2:0] bit_role, [3] packet_end
  output logic       m_axis_tlast    // run_last: final bit caused by one input byte
);

  // The sequencer steps through a small microprogram:
  //   wait -> preamble (loop) -> start -> data (loop x8) -> separator
  //   separator -> checksum (loop x8) -> end -> wait   on a last byte
  //   separator or wait -> data   when a byte of an open packet is taken there
  // Every emitting step advances only when the output register is free.

  dps_pkg::ctrl_t   ctrl;
  dps_pkg::status_t status;
  logic             line_bit;
  dps_pkg::role_e   bit_role;
  logic             packet_end;

  dps_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  dps_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .data_byte_i  (s_axis_tdata),
    .last_byte_i  (s_axis_tlast),
    .ctrl_i       (ctrl),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .line_bit_o   (line_bit),
    .bit_role_o   (bit_role),
    .run_last_o   (m_axis_tlast),
    .packet_end_o (packet_end)
  );

  assign m_axis_tdata = {7'b0, line_bit};
  assign m_axis_tuser = {packet_end, bit_role};

endmodule

// ----- rtl/dps_checker.sv -----
// Port-level checker for the DCC packet bit serializer, bound to the top level.
module dps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [3:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // A closing end bit is always a one and ends the byte's run.
  a_end_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[3]) |->
      (m_axis_tlast && m_axis_tdata[0] && (m_axis_tuser[2:0] == dps_pkg::ROLE_END)))
    else $error("packet end bit malformed");

  // A run only ends on a separator or an end bit.
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      ((m_axis_tuser[2:0] == dps_pkg::ROLE_SEPARATOR) ||
       (m_axis_tuser[2:0] == dps_pkg::ROLE_END)))
    else $error("run ended on wrong bit role");

  // Preamble bits are ones, start and separator bits are zeros.
  a_fixed_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (((m_axis_tuser[2:0] == dps_pkg::ROLE_PREAMBLE) && m_axis_tdata[0]) ||
       ((m_axis_tuser[2:0] == dps_pkg::ROLE_START) && !m_axis_tdata[0]) ||
       ((m_axis_tuser[2:0] == dps_pkg::ROLE_SEPARATOR) && !m_axis_tdata[0]) ||
       (m_axis_tuser[2:0] == dps_pkg::ROLE_DATA) ||
       (m_axis_tuser[2:0] == dps_pkg::ROLE_CHECKSUM) ||
       (m_axis_tuser[2:0] == dps_pkg::ROLE_END)))
    else $error("fixed framing bit has wrong value");

  // A stalled transaction holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("stalled output changed");

endmodule

bind dcc_packet_bit_serializer dps_checker u_dps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- bench/tb_dcc_packet_bit_serializer.sv -----
// Testbench for the DCC packet bit serializer: random packets in, bit-exact line bit checks out.

class dcc_line_checker;
  typedef struct packed {
    logic           line_bit;
    dps_pkg::role_e role;
    logic           run_last;
    logic           pkt_end;
  } line_bit_t;

  line_bit_t   pending_bits[$];
  int unsigned preamble_len = dps_pkg::PREAMBLE_RST;
  logic [7:0]  xor_sum      = 8'h00;
  bit          in_packet    = 1'b0;
  int          mismatches   = 0;
  int          bits_checked = 0;

  task flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH line bit %0d: %s", bits_checked, msg);
  endtask

  // Register write: 0 acts as 1, anything above the max acts as the max.
  function void load_preamble(logic [5:0] value);
    if (value > dps_pkg::PREAMBLE_MAX) preamble_len = dps_pkg::PREAMBLE_MAX;
    else if (value == 6'd0) preamble_len = 1;
    else preamble_len = value;
  endfunction

  function void push_bit(logic b, dps_pkg::role_e r, logic pe = 1'b0);
    line_bit_t e;
    e.line_bit = b;
    e.role     = r;
    e.run_last = 1'b0;
    e.pkt_end  = pe;
    pending_bits.push_back(e);
  endfunction

  // Frame one accepted byte into the line bits it must produce.
  function void frame_byte(logic [7:0] data, logic last);
    int        i;
    line_bit_t tail;
    if (!in_packet) begin
      repeat (preamble_len) push_bit(1'b1, dps_pkg::ROLE_PREAMBLE);
      push_bit(1'b0, dps_pkg::ROLE_START);
      in_packet = 1'b1;
    end
    for (i = dps_pkg::BYTE_BITS - 1; i >= 0; i--) push_bit(data[i], dps_pkg::ROLE_DATA);
    push_bit(1'b0, dps_pkg::ROLE_SEPARATOR);
    xor_sum = xor_sum ^ data;
    if (last) begin
      for (i = dps_pkg::BYTE_BITS - 1; i >= 0; i--)
        push_bit(xor_sum[i], dps_pkg::ROLE_CHECKSUM);
      push_bit(1'b1, dps_pkg::ROLE_END, 1'b1);
      xor_sum   = 8'h00;
      in_packet = 1'b0;
    end
    tail = pending_bits.pop_back();
    tail.run_last = 1'b1;
    pending_bits.push_back(tail);
  endfunction

  task check_line_bit(input logic [7:0] tdata, input logic [3:0] tuser, input logic tlast);
    line_bit_t want;
    bits_checked++;
    if (pending_bits.size() == 0) begin
      flag_mismatch($sformatf("unexpected bit tdata=%h tuser=%h tlast=%b", tdata, tuser, tlast));
      return;
    end
    want = pending_bits.pop_front();
    if (tdata !== {7'b0, want.line_bit})
      flag_mismatch($sformatf("tdata %h, want line_bit %b", tdata, want.line_bit));
    if (tuser[2:0] !== want.role)
      flag_mismatch($sformatf("bit_role %0d, want %s", tuser[2:0], want.role.name()));
    if (tuser[3] !== want.pkt_end)
      flag_mismatch($sformatf("packet_end %b, want %b", tuser[3], want.pkt_end));
    if (tlast !== want.run_last)
      flag_mismatch($sformatf("run_last %b, want %b", tlast, want.run_last));
  endtask
endclass

module tb_dcc_packet_bit_serializer;

  localparam int RESET_CYCLES   = 12;
  localparam int SINK_HOLD      = 300;   // long sink back-pressure stretch
  localparam int DRAIN_CYCLES   = 24;    // settle time after the last expected bit
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [5:0] cfg_wdata_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] data_byte
  logic       s_axis_tlast;   // last_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [0] line_bit, [7:1] zero
  logic [3:0] m_axis_tuser;   // [2:0] bit_role, [3] packet_end
  logic       m_axis_tlast;   // run_last

  dcc_line_checker lines = new;

  int bytes_sent    = 0;
  int quiet_cycles  = 0;
  bit src_idle_en   = 1'b1;
  bit sink_idle_en  = 1'b1;
  bit sink_hold_req = 1'b0;

  dcc_packet_bit_serializer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Source gap: valid drops, and the data lines carry junk, for a stretch set by n.
  task automatic source_gap(input int n);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'($urandom);
    s_axis_tlast  <= 1'($urandom);
    repeat (n - 1) @(negedge clk_i);
  endtask

  // One byte transaction. Valid stays up across back-to-back calls; the next
  // call simply rewrites data at the following falling edge.
  task automatic send_byte(input logic [7:0] data, input logic last);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    lines.frame_byte(data, last);
    bytes_sent++;
    if (src_idle_en && $urandom_range(0, 3) == 0) source_gap($urandom_range(1, 6));
  endtask

  task automatic send_packet(input int len);
    int k;
    for (k = 0; k < len; k++) send_byte(8'($urandom), k == len - 1);
  endtask

  // Stop offering and wait until every predicted line bit is out, then settle.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (lines.pending_bits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Only called with the block idle (after reset or after a drain).
  task automatic write_preamble(input logic [5:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 6'($urandom);
    lines.load_preamble(value);
  endtask

  // Mostly DCC-sized packets (1..6 bytes), now and then an overlong one.
  task automatic packet_phase(input int n_items);
    int stop_at;
    stop_at = bytes_sent + n_items;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) send_packet($urandom_range(7, 20));
      else send_packet($urandom_range(1, 6));
    end
    drain();
  endtask

  // Sink: random stall bursts, ready runs of varying length,
  // and one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (SINK_HOLD - 1) @(negedge clk_i);
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(negedge clk_i);
        else repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end
    end
  end

  // Line bit monitor, sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
      lines.check_line_bit(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // Watchdog: any transaction on either side resets the count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_dcc_packet_bit_serializer NOT OK");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 6'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset preamble length: single-byte packets at both data
    // extremes, then multi-byte packets whose checksum bits differ.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h3C, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h7F, 1'b1);
    drain();

    // Preamble written as zero acts as a single one bit.
    write_preamble(6'd0);
    send_byte(8'h55, 1'b1);
    drain();
    // All ones and just above the max both clamp to the max: 51 bits per single-byte packet.
    write_preamble(6'd63);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h33, 1'b0);
    send_byte(8'hCC, 1'b1);
    drain();
    write_preamble(6'd33);
    send_byte(8'h0F, 1'b1);
    drain();
    write_preamble(6'd1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hF0, 1'b1);
    drain();

    // Long sink hold-off with the source offering back to back, so the block
    // backs up and stalls its input.
    write_preamble(6'd32);
    src_idle_en   = 1'b0;
    sink_hold_req = 1'b1;
    send_packet(12);
    src_idle_en   = 1'b1;
    drain();

    // Random phases, each under its own preamble length.
    packet_phase(60);
    repeat (5) begin
      write_preamble(6'($urandom));
      packet_phase(60);
    end

    // Tail of the run: no idling on either side.
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    write_preamble(6'($urandom_range(1, 32)));
    packet_phase(40);

    if (lines.pending_bits.size() != 0) lines.flag_mismatch("line bits still expected at end");
    if (lines.mismatches == 0) begin
      $display("tb_dcc_packet_bit_serializer OK");
    end else begin
      $display("tb_dcc_packet_bit_serializer NOT OK");
    end
    $finish;
  end

endmodule

// ----- dcc_packet_bit_serializer.f -----
rtl/dps_pkg.sv
rtl/dps_seq.sv
rtl/dps_dp.sv
rtl/dcc_packet_bit_serializer.sv
rtl/dps_checker.sv
bench/tb_dcc_packet_bit_serializer.sv
